// ===== design/ecwt_pkg.sv =====
// Shared types, constants and codes of the erase count wear tracker.
`default_nettype none
package ecwt_pkg;

    // Field widths.
    localparam int ADDR_W     = 20;
    localparam int DEV_W      = 5;
    localparam int CNT_W      = 32;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MAP_W      = 32;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 176;

    // Parameter defaults.
    localparam int BLOCKS_DEF         = 4096;
    localparam int SEGS_PER_BLOCK_DEF = 256;
    localparam int DEVICES_DEF        = 32;
    localparam int WRAP_DEVICE_DEF    = 4;

    // Register reset values.
    localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd16;
    localparam logic [DEV_W-1:0] DEVICE_RST    = 5'd0;
    localparam logic [MAP_W-1:0] BAD_MAP_RST   = 32'h0000_FFCF;
    localparam logic [CNT_W-1:0] MAX_RST       = 32'd0;
    localparam logic [CNT_W-1:0] TOTAL_RST     = 32'd0;
    localparam logic [CNT_W-1:0] SEQUENCE_RST  = 32'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLUSH_THRESHOLD = 3'd0,
        CFG_START_DEVICE    = 3'd1,
        CFG_START_BAD_MAP   = 3'd2,
        CFG_START_MAX       = 3'd3,
        CFG_START_TOTAL     = 3'd4,
        CFG_START_SEQUENCE  = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_COMPLETE,
        ST_FLUSH,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic clear;
        logic read;
        logic update;
        logic complete;
        logic flush;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic write_ok;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// ===== design/ecwt_dev_pick.sv =====
// Picks the next usable device after the active one, wrapping to a fixed device.
`default_nettype none
module ecwt_dev_pick
    import ecwt_pkg::*;
#(
    parameter int DEVICES     = DEVICES_DEF,
    parameter int WRAP_DEVICE = WRAP_DEVICE_DEF
) (
    input  wire logic [DEV_W-1:0] cur_dev,
    input  wire logic [MAP_W-1:0] bad_map,
    output logic                  pick_ok,
    output logic [DEV_W-1:0]      pick_dev
);

    logic [MAP_W-1:0] after_mask;
    logic [MAP_W-1:0] wrap_mask;
    logic [MAP_W-1:0] sel_mask;
    logic [MAP_W-1:0] lowest;

    // The walk first covers the devices above the active one, then restarts
    // at the wrap device; the first good device of that order is the lowest
    // set bit of the first nonempty mask.
    always_comb begin
        for (int i = 0; i < MAP_W; i++) begin
            after_mask[i] = (i < DEVICES) && !bad_map[i] && (5'(i) > cur_dev);
            wrap_mask[i]  = (i < DEVICES) && !bad_map[i] && (i >= WRAP_DEVICE);
        end
        sel_mask = (|after_mask) ? after_mask : wrap_mask;
        lowest   = sel_mask & (~sel_mask + MAP_W'(1));
        pick_ok  = |(after_mask | wrap_mask);
        pick_dev = '0;
        for (int i = 0; i < MAP_W; i++) begin
            pick_dev = pick_dev | (lowest[i] ? 5'(i) : 5'd0);
        end
    end

endmodule
`default_nettype wire

// ===== design/ecwt_ctrl.sv =====
// Sequencer of the wear tracker: clearing pass, erase and flush completion steps.
`default_nettype none
module ecwt_ctrl
    import ecwt_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    input  wire logic req_type,
    output logic      s_tready,
    input  wire stat_t stat,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = req_type ? ST_COMPLETE : ST_READ;
                end
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_COMPLETE: begin
                cmd.complete = 1'b1;
                state_next   = stat.write_ok ? ST_OUTPUT : ST_FLUSH;
            end
            ST_FLUSH: begin
                cmd.flush  = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    erase_path_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !req_type) |=>
            (state_reg == ST_READ) ##1 (state_reg == ST_UPDATE) ##1 (state_reg == ST_OUTPUT))
        else $error("erase transaction did not run read, update, output");

    no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && !stat.clear_last) |=> !s_tready)
        else $error("input accepted before the clearing pass ended");

endmodule
`default_nettype wire

// ===== design/ecwt_datapath.sv =====
// Count memory, tracked figures, device state and the result register.
`default_nettype none
module ecwt_datapath
    import ecwt_pkg::*;
#(
    parameter int BLOCKS         = BLOCKS_DEF,
    parameter int SEGS_PER_BLOCK = SEGS_PER_BLOCK_DEF,
    parameter int DEVICES        = DEVICES_DEF,
    parameter int WRAP_DEVICE    = WRAP_DEVICE_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata
);

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    // Block index = address / SEGS_PER_BLOCK through a rounded-up reciprocal;
    // the shift is large enough that the quotient is exact for 20-bit addresses.
    localparam int SHIFT   = ADDR_W + $clog2(SEGS_PER_BLOCK);
    localparam int RECIP_W = ADDR_W + 2;
    localparam int PROD_W  = ADDR_W + RECIP_W;
    localparam longint unsigned SPAN    = 64'd1 << SHIFT;
    localparam longint unsigned RECIP_L = (SPAN + SEGS_PER_BLOCK - 1) / SEGS_PER_BLOCK;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int OUT_USED = 4 * CNT_W + 1 + DEV_W + CNT_W + DEV_W + 1;

    logic [CNT_W-1:0] mem [BLOCKS];

    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              ok_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              inr_reg;
    logic [CNT_W-1:0]  rdata_reg;

    logic [THR_W-1:0] thr_reg,   thr_next;
    logic [CNT_W-1:0] min_reg,   min_next;
    logic [CNT_W-1:0] max_reg,   max_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [THR_W-1:0] upd_reg,   upd_next;
    logic [MAP_W-1:0] bad_reg,   bad_next;
    logic [DEV_W-1:0] cur_reg,   cur_next;
    logic [DEV_W-1:0] tgt_reg,   tgt_next;
    logic [CNT_W-1:0] seq_reg,   seq_next;
    logic [CNT_W-1:0] bcnt_reg,  bcnt_next;
    logic             flush_reg, flush_next;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [ADDR_W-1:0] blk;
    logic [CNT_W-1:0]  cnt_new;
    logic [THR_W-1:0]  upd_inc;
    logic              thr_hit;
    logic              pick_ok;
    logic [DEV_W-1:0]  pick_dev;

    ecwt_dev_pick #(
        .DEVICES     (DEVICES),
        .WRAP_DEVICE (WRAP_DEVICE)
    ) u_pick (
        .cur_dev  (cur_reg),
        .bad_map  (bad_reg),
        .pick_ok  (pick_ok),
        .pick_dev (pick_dev)
    );

    assign blk     = ADDR_W'(prod_reg >> SHIFT);
    assign cnt_new = rdata_reg + CNT_W'(1);
    assign upd_inc = upd_reg + THR_W'(1);
    assign thr_hit = (upd_inc >= thr_reg);

    always_comb begin
        thr_next   = thr_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        total_next = total_reg;
        upd_next   = upd_reg;
        bad_next   = bad_reg;
        cur_next   = cur_reg;
        tgt_next   = tgt_reg;
        seq_next   = seq_reg;
        bcnt_next  = bcnt_reg;
        flush_next = flush_reg;

        if (cmd.update) begin
            bcnt_next  = '0;
            flush_next = 1'b0;
            if (inr_reg) begin
                bcnt_next = cnt_new;
                upd_next  = thr_hit ? '0 : upd_inc;
                if (cnt_new < min_reg) begin
                    min_next = cnt_new;
                end else if (cnt_new > max_reg) begin
                    max_next = cnt_new;
                end
                // The active device and bad map do not change on an erase,
                // so the flush pick can be taken in the same step.
                if (thr_hit && pick_ok) begin
                    flush_next = 1'b1;
                    tgt_next   = pick_dev;
                    seq_next   = seq_reg + CNT_W'(1);
                    total_next = total_reg + CNT_W'(2);
                end else begin
                    total_next = total_reg + CNT_W'(1);
                end
            end
        end

        if (cmd.complete) begin
            bcnt_next  = '0;
            flush_next = 1'b0;
            if (ok_reg) begin
                cur_next = tgt_reg;
            end else begin
                bad_next = bad_reg | (MAP_W'(1) << tgt_reg);
            end
        end

        if (cmd.flush) begin
            flush_next = pick_ok;
            if (pick_ok) begin
                tgt_next   = pick_dev;
                seq_next   = seq_reg + CNT_W'(1);
                total_next = total_reg + CNT_W'(1);
            end
        end

        if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_FLUSH_THRESHOLD: thr_next = cfg_wdata[THR_W-1:0];
                CFG_START_DEVICE: begin
                    cur_next = cfg_wdata[DEV_W-1:0];
                    tgt_next = cfg_wdata[DEV_W-1:0];
                end
                CFG_START_BAD_MAP:  bad_next   = cfg_wdata;
                CFG_START_MAX:      max_next   = cfg_wdata;
                CFG_START_TOTAL:    total_next = cfg_wdata;
                CFG_START_SEQUENCE: seq_next   = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= THRESHOLD_RST;
            min_reg      <= '0;
            max_reg      <= MAX_RST;
            total_reg    <= TOTAL_RST;
            upd_reg      <= '0;
            bad_reg      <= BAD_MAP_RST;
            cur_reg      <= DEVICE_RST;
            tgt_reg      <= DEVICE_RST;
            seq_reg      <= SEQUENCE_RST;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            thr_reg   <= thr_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            total_reg <= total_next;
            upd_reg   <= upd_next;
            bad_reg   <= bad_next;
            cur_reg   <= cur_next;
            tgt_reg   <= tgt_next;
            seq_reg   <= seq_next;
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bcnt_reg  <= bcnt_next;
        flush_reg <= flush_next;
        if (cmd.accept) begin
            prod_reg <= PROD_W'(s_tdata[ADDR_W-1:0]) * PROD_W'(RECIP);
            ok_reg   <= s_tdata[ADDR_W];
        end
        if (cmd.read) begin
            idx_reg <= blk[IDX_W-1:0];
            inr_reg <= (32'(blk) < BLOCKS);
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {(M_TDATA_W - OUT_USED)'(0), !pick_ok, cur_reg, seq_reg,
                            tgt_reg, flush_reg, total_reg, min_reg, max_reg, bcnt_reg};
        end
    end

    // Count memory: one write port for the clearing pass and the update,
    // one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            mem[clr_cnt_reg] <= '0;
        end else if (cmd.update && inr_reg) begin
            mem[idx_reg] <= cnt_new;
        end
        if (cmd.read) begin
            rdata_reg <= mem[blk[IDX_W-1:0]];
        end
    end

    assign stat.clear_last = (clr_cnt_reg == IDX_W'(BLOCKS - 1));
    assign stat.write_ok   = ok_reg;
    assign stat.out_free   = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

    flush_target_good: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && flush_reg) |-> (!bad_reg[tgt_reg] && pick_ok))
        else $error("flush reported to a bad device or with no usable device");

    flush_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.flush && pick_ok) |=> (seq_reg == $past(seq_reg) + CNT_W'(1)))
        else $error("flush did not advance the sequence by one");

    update_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> $past(cmd.read))
        else $error("count update without a preceding memory read");

endmodule
`default_nettype wire

// ===== design/erase_count_wear_tracker.sv =====
// Top level of the erase count wear tracker: sequencer and datapath.
// An erase transaction's result is loaded after scaling, count read and update with flush pick,
// and the next one is taken only once it is loaded; a held result adds its m_tready wait.
// A good flush completion runs a complete step before its output, a failed one a flush step too.
// After aresetn, a clearing pass zeroes every count memory entry with s_tready low;
// configuration writes are taken. Only one transaction is in flight at a time.
`default_nettype none
module erase_count_wear_tracker
    import ecwt_pkg::*;
#(
    parameter int BLOCKS         = BLOCKS_DEF,
    parameter int SEGS_PER_BLOCK = SEGS_PER_BLOCK_DEF,
    parameter int DEVICES        = DEVICES_DEF,
    parameter int WRAP_DEVICE    = WRAP_DEVICE_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // phys_address[19:0], write_ok[20], zero[23:21]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // req_type[0]
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // block_count[31:0], max_count[63:32], min_count[95:64], total_erases[127:96],
    // flush_request[128], flush_device[133:129], sequence_res[165:134],
    // active_device[170:166], all_bad[171], zero[175:172]
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cmd_t  cmd;
    stat_t stat;

    ecwt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ecwt_datapath #(
        .BLOCKS         (BLOCKS),
        .SEGS_PER_BLOCK (SEGS_PER_BLOCK),
        .DEVICES        (DEVICES),
        .WRAP_DEVICE    (WRAP_DEVICE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// ===== tb/tb_erase_count_wear_tracker.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the erase count wear tracker: directed corners, then random traffic.
module tb_erase_count_wear_tracker;
    import ecwt_pkg::*;

    localparam logic REQ_ERASE      = 1'b0;
    localparam logic REQ_FLUSH_DONE = 1'b1;
    localparam int   BLK_W          = $clog2(BLOCKS_DEF);

    typedef struct {
        logic [CNT_W-1:0] block_count;
        logic [CNT_W-1:0] max_count;
        logic [CNT_W-1:0] min_count;
        logic [CNT_W-1:0] total_erases;
        logic             flush_request;
        logic [DEV_W-1:0] flush_device;
        logic [CNT_W-1:0] sequence_res;
        logic [DEV_W-1:0] active_device;
        logic             all_bad;
    } wear_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [M_TDATA_W-1:0]   m_tdata;

    erase_count_wear_tracker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Wear model state and settings.
    logic [CNT_W-1:0] wear_cnt [BLOCKS_DEF];
    logic [THR_W-1:0] thr_setting;
    logic [THR_W-1:0] upd_count;
    logic [CNT_W-1:0] trk_min;
    logic [CNT_W-1:0] trk_max;
    logic [CNT_W-1:0] trk_total;
    logic [MAP_W-1:0] bad_devs;
    logic [DEV_W-1:0] active_dev;
    logic [DEV_W-1:0] target_dev;
    logic [CNT_W-1:0] seq_no;

    wear_result_t expected_q[$];
    wear_result_t got_r;
    wear_result_t want_r;
    int  errors     = 0;
    int  n_erase    = 0;
    int  n_done     = 0;
    int  n_flush    = 0;
    int  n_results  = 0;
    int  n_settings = 0;
    int  next_gap   = 0;
    bit  send_burst = 1'b0;
    bit  recv_burst = 1'b0;
    bit  flush_open = 1'b0;
    int unsigned hot_blk [8];

    function automatic void reset_wear_model();
        int b;
        for (b = 0; b < BLOCKS_DEF; b++) wear_cnt[b[BLK_W-1:0]] = '0;
        thr_setting = THRESHOLD_RST;
        upd_count   = '0;
        trk_min     = '0;
        trk_max     = MAX_RST;
        trk_total   = TOTAL_RST;
        bad_devs    = BAD_MAP_RST;
        active_dev  = DEVICE_RST;
        target_dev  = DEVICE_RST;
        seq_no      = SEQUENCE_RST;
    endfunction

    // Walks forward from the active device, jumping to the wrap device past the end.
    function automatic logic pick_next_device(output logic [DEV_W-1:0] dev);
        int unsigned d;
        d = 32'(active_dev);
        dev = '0;
        repeat (33) begin
            d = d + 1;
            if (d >= DEVICES_DEF) d = WRAP_DEVICE_DEF;
            if (d < DEVICES_DEF && !bad_devs[d[DEV_W-1:0]]) begin
                dev = d[DEV_W-1:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic launch_flush();
        logic [DEV_W-1:0] dev;
        if (!pick_next_device(dev)) return 1'b0;
        target_dev = dev;
        trk_total  = trk_total + 1;
        seq_no     = seq_no + 1;
        return 1'b1;
    endfunction

    function automatic wear_result_t predict_wear(logic req, logic [ADDR_W-1:0] addr, logic ok);
        wear_result_t     r;
        int unsigned      blk;
        logic [CNT_W-1:0] c;
        logic [DEV_W-1:0] spare;
        r.block_count   = '0;
        r.flush_request = 1'b0;
        if (req == REQ_ERASE) begin
            blk = addr / SEGS_PER_BLOCK_DEF;
            if (blk < BLOCKS_DEF) begin
                c = wear_cnt[blk[BLK_W-1:0]] + 1;
                wear_cnt[blk[BLK_W-1:0]] = c;
                r.block_count = c;
                trk_total = trk_total + 1;
                upd_count = upd_count + THR_W'(1);
                if (c < trk_min) trk_min = c;
                else if (c > trk_max) trk_max = c;
                if (upd_count >= thr_setting) begin
                    upd_count = '0;
                    r.flush_request = launch_flush();
                end
            end
        end else if (ok) begin
            active_dev = target_dev;
        end else begin
            bad_devs[target_dev] = 1'b1;
            r.flush_request = launch_flush();
        end
        r.max_count     = trk_max;
        r.min_count     = trk_min;
        r.total_erases  = trk_total;
        r.flush_device  = target_dev;
        r.sequence_res  = seq_no;
        r.active_device = active_dev;
        r.all_bad       = !pick_next_device(spare);
        return r;
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        // Start registers load the live state at once.
        case (idx)
            CFG_FLUSH_THRESHOLD: thr_setting = val[THR_W-1:0];
            CFG_START_DEVICE: begin
                active_dev = val[DEV_W-1:0];
                target_dev = val[DEV_W-1:0];
            end
            CFG_START_BAD_MAP:  bad_devs  = val;
            CFG_START_MAX:      trk_max   = val;
            CFG_START_TOTAL:    trk_total = val;
            CFG_START_SEQUENCE: seq_no    = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [THR_W-1:0] thr, logic [DEV_W-1:0] dev,
                                 logic [MAP_W-1:0] bad, logic [CNT_W-1:0] maxc,
                                 logic [CNT_W-1:0] total, logic [CNT_W-1:0] seqv);
        write_reg(CFG_FLUSH_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_START_DEVICE, CFG_DATA_W'(dev));
        write_reg(CFG_START_BAD_MAP, bad);
        write_reg(CFG_START_MAX, maxc);
        write_reg(CFG_START_TOTAL, total);
        write_reg(CFG_START_SEQUENCE, seqv);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Valid stays high after a transaction only when the next one follows without a gap.
    task automatic send_item(logic req, logic [ADDR_W-1:0] addr, logic ok);
        wear_result_t r;
        repeat (next_gap) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-ADDR_W-1){1'b0}}, ok, addr};
        s_tuser  <= req;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_wear(req, addr, ok);
        expected_q.push_back(r);
        if (req == REQ_ERASE) n_erase++;
        else n_done++;
        if (r.flush_request) n_flush++;
        flush_open = (req == REQ_FLUSH_DONE) ? r.flush_request : (flush_open || r.flush_request);
        next_gap = send_burst ? 0 : $urandom_range(0, 5);
        if (next_gap != 0) s_tvalid <= 1'b0;
    endtask

    task automatic settle_block();
        if (next_gap == 0) s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic test_defaults();
        // Reset settings: address extremes, and block 0 erased twice.
        send_item(REQ_ERASE, '0, 1'b0);
        send_item(REQ_ERASE, '1, 1'b1);
        send_item(REQ_ERASE, 20'h000FF, 1'b0);
        settle_block();
    endtask

    task automatic test_register_extremes();
        // Device 31 wraps to the wrap device; total and sequence roll over.
        load_settings(16'd1, 5'd31, 32'h0, '1, 32'hFFFF_FFFE, '1);
        send_item(REQ_ERASE, ADDR_W'($urandom), 1'b1);
        send_item(REQ_FLUSH_DONE, ADDR_W'($urandom), 1'b1);
        send_item(REQ_ERASE, ADDR_W'($urandom), 1'b0);
        send_item(REQ_FLUSH_DONE, ADDR_W'($urandom), 1'b0);
        send_item(REQ_FLUSH_DONE, ADDR_W'($urandom), 1'b1);
        settle_block();
        // A zero threshold flushes on every erase; the low devices are reachable from device 0.
        load_settings(16'd0, 5'd0, 32'hFFFF_FFF1, 32'd0, 32'd0, 32'd0);
        send_item(REQ_ERASE, 20'h00100, 1'b0);
        send_item(REQ_ERASE, 20'h00100, 1'b1);
        send_item(REQ_FLUSH_DONE, '1, 1'b1);
        send_item(REQ_FLUSH_DONE, '0, 1'b0);
        send_item(REQ_FLUSH_DONE, ADDR_W'($urandom), 1'b1);
        settle_block();
    endtask

    task automatic test_no_usable_device();
        load_settings(16'hFFFF, 5'd9, '1, 32'd5, 32'd100, 32'd7);
        send_item(REQ_ERASE, ADDR_W'($urandom), 1'b0);
        send_item(REQ_ERASE, ADDR_W'($urandom), 1'b1);
        send_item(REQ_FLUSH_DONE, ADDR_W'($urandom), 1'b0);
        send_item(REQ_FLUSH_DONE, ADDR_W'($urandom), 1'b1);
        settle_block();
        // Only device 7 is usable; its failed write leaves nothing to pick.
        load_settings(16'd1, 5'd3, ~(32'd1 << 7), 32'd0, 32'd0, 32'd1);
        send_item(REQ_ERASE, ADDR_W'($urandom), 1'b0);
        send_item(REQ_FLUSH_DONE, ADDR_W'($urandom), 1'b0);
        settle_block();
    endtask

    task automatic test_random_traffic();
        int p;
        int i;
        int k;
        logic [THR_W-1:0] thr;
        logic [MAP_W-1:0] bad;
        logic [CNT_W-1:0] maxc;
        logic [ADDR_W-1:0] a;
        for (p = 0; p < 9; p++) begin
            case ($urandom_range(0, 9))
                0:       thr = '0;
                1:       thr = THR_W'($urandom_range(7, 40));
                default: thr = THR_W'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 5))
                0:       bad = '0;
                1:       bad = ~(32'd1 << $urandom_range(0, 31));
                2, 3:    bad = $urandom & $urandom;
                default: bad = $urandom & $urandom & $urandom;
            endcase
            maxc = $urandom_range(0, 1) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
                                        : 32'($urandom_range(0, 30));
            load_settings(thr, DEV_W'($urandom_range(0, 31)), bad, maxc, $urandom, $urandom);
            for (k = 0; k < 8; k++) hot_blk[k[2:0]] = $urandom_range(0, BLOCKS_DEF - 1);
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            // Mostly erases on a few hot blocks; while a flush is open, most items answer it with a completion.
            for (i = 0; i < 148; i++) begin
                k = $urandom_range(0, 99);
                if (flush_open && k < 80) begin
                    send_item(REQ_FLUSH_DONE, ADDR_W'($urandom), $urandom_range(0, 3) != 0);
                end else if (k < 4) begin
                    send_item(REQ_FLUSH_DONE, ADDR_W'($urandom), 1'($urandom_range(0, 1)));
                end else begin
                    if ($urandom_range(0, 9) < 7)
                        a = ADDR_W'(hot_blk[3'($urandom_range(0, 7))] * SEGS_PER_BLOCK_DEF
                                    + $urandom_range(0, SEGS_PER_BLOCK_DEF - 1));
                    else
                        a = ADDR_W'($urandom_range(0, 20'hFFFFF));
                    send_item(REQ_ERASE, a, 1'($urandom_range(0, 1)));
                end
            end
            settle_block();
            send_burst = 1'b0;
            recv_burst = 1'b0;
        end
    endtask

    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = recv_burst ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    function automatic void check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_r.block_count   = m_tdata[31:0];
            got_r.max_count     = m_tdata[63:32];
            got_r.min_count     = m_tdata[95:64];
            got_r.total_erases  = m_tdata[127:96];
            got_r.flush_request = m_tdata[128];
            got_r.flush_device  = m_tdata[133:129];
            got_r.sequence_res  = m_tdata[165:134];
            got_r.active_device = m_tdata[170:166];
            got_r.all_bad       = m_tdata[171];
            n_results++;
            if (expected_q.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, got %0h",
                         $time, m_tdata);
                errors++;
            end else begin
                want_r = expected_q.pop_front();
                check_field("block_count", want_r.block_count, got_r.block_count);
                check_field("max_count", want_r.max_count, got_r.max_count);
                check_field("min_count", want_r.min_count, got_r.min_count);
                check_field("total_erases", want_r.total_erases, got_r.total_erases);
                check_field("flush_request", 32'(want_r.flush_request), 32'(got_r.flush_request));
                check_field("flush_device", 32'(want_r.flush_device), 32'(got_r.flush_device));
                check_field("sequence_res", want_r.sequence_res, got_r.sequence_res);
                check_field("active_device", 32'(want_r.active_device), 32'(got_r.active_device));
                check_field("all_bad", 32'(want_r.all_bad), 32'(got_r.all_bad));
            end
        end
    end

    initial begin
        reset_wear_model();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_defaults();
        test_register_extremes();
        test_no_usable_device();
        test_random_traffic();
        $display("Covered %0d erase and %0d completion transactions under %0d register settings.",
                 n_erase, n_done, n_settings);
        $display("Checked %0d results, %0d of them flush requests.", n_results, n_flush);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("erase_count_wear_tracker: match");
        end else begin
            $display("erase_count_wear_tracker: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results outstanding.", expected_q.size());
        $display("erase_count_wear_tracker: mismatch");
        $finish;
    end

endmodule
